// ===== rtl/dependency_counter_task_trigger_macros.svh =====
// Assertion macros for the dependency counter task trigger.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef DEPENDENCY_COUNTER_TASK_TRIGGER_MACROS_SVH
`define DEPENDENCY_COUNTER_TASK_TRIGGER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DCT_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DCT_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`endif

// ===== rtl/dct_pkg.sv =====
// Shared types and constants of the dependency counter task trigger.
// No dependencies; used by dct_ctrl, dct_dpath and the top level.
package dct_pkg;

  localparam int NodeCountDef   = 8;
  localparam int CounterBitsDef = 16;
  localparam int NodeW          = 3;
  localparam int DeltaW         = 16;
  localparam int PrioW          = 3;
  localparam int EdgeW          = 64;
  localparam int PrioRegW       = 24;
  localparam int CfgIdxW        = 1;
  localparam int CfgDataW       = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EDGE_MATRIX = 1'b0,
    CFG_NODE_PRIO   = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ERR_OK  = 2'd0,
    ERR_NEG = 2'd1,
    ERR_SAT = 2'd2
  } err_code_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  typedef struct packed {
    logic [NodeW-1:0]         node;
    logic signed [DeltaW-1:0] delta;
  } in_item_t;

  typedef struct packed {
    logic             fired;
    logic [NodeW-1:0] task_index;
    logic [PrioW-1:0] priority_res;
    err_code_e        error_code;
    logic             last;
  } res_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic calc;
    logic emit;
  } dct_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last;
  } dct_sts_t;

endpackage

// ===== rtl/dct_ctrl.sv =====
// Sequencer of the dependency counter task trigger: idle, update, emit.
// Depends on dct_pkg.
module dct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  dct_pkg::dct_sts_t sts_i,
  output dct_pkg::dct_cmd_t cmd_o,
  output logic              busy_o
);

  dct_pkg::state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    case (state_q)
      dct_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = dct_pkg::ST_CALC;
        end
      end
      dct_pkg::ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = dct_pkg::ST_EMIT;
      end
      dct_pkg::ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.last) begin
          state_d = dct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dct_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dct_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != dct_pkg::ST_IDLE);

endmodule

// ===== rtl/dct_dpath.sv =====
// Datapath of the dependency counter task trigger: counters, fired flags,
// config registers, release mask and result register. Depends on dct_pkg.
`include "dependency_counter_task_trigger_macros.svh"

module dct_dpath #(
  parameter int NODE_COUNT   = dct_pkg::NodeCountDef,
  parameter int COUNTER_BITS = dct_pkg::CounterBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dct_pkg::dct_cmd_t             cmd_i,
  output dct_pkg::dct_sts_t             sts_o,
  input  dct_pkg::in_item_t             item_i,
  input  logic                          cfg_we_i,
  input  logic [dct_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dct_pkg::CfgDataW-1:0]  cfg_data_i,
  output dct_pkg::res_item_t            res_o,
  output logic                          res_valid_o
);

  localparam int NodeIdxW = $clog2(NODE_COUNT);
  localparam int CalcW    = ((COUNTER_BITS > dct_pkg::DeltaW) ?
                             COUNTER_BITS : dct_pkg::DeltaW) + 2;
  localparam logic [COUNTER_BITS-1:0] CntMax = {COUNTER_BITS{1'b1}};

  logic [dct_pkg::EdgeW-1:0]    edge_q;
  logic [dct_pkg::PrioRegW-1:0] prio_q;
  logic [COUNTER_BITS-1:0]      cnt_q [NODE_COUNT];
  logic [NODE_COUNT-1:0]        fired_q;
  logic [NODE_COUNT-1:0]        fire_q;
  dct_pkg::in_item_t            item_q;
  dct_pkg::err_code_e           err_q;
  dct_pkg::res_item_t           res_q;
  logic                         res_valid_q;

  logic                    node_ok;
  logic [NodeIdxW-1:0]     node_idx;
  logic [COUNTER_BITS-1:0] cnt_cur;
  logic [CalcW-1:0]        sum;
  logic [COUNTER_BITS-1:0] cnt_nxt;
  dct_pkg::err_code_e      err_d;
  logic [NODE_COUNT-1:0]   zero_v;
  logic [NODE_COUNT-1:0]   fire_d;
  logic [NODE_COUNT-1:0]   pick;
  logic [dct_pkg::NodeW-1:0] pick_idx;
  logic [dct_pkg::PrioW-1:0] pick_prio;
  logic                    found;

  assign node_ok  = ({1'b0, item_q.node} < (dct_pkg::NodeW + 1)'(NODE_COUNT));
  assign node_idx = item_q.node[NodeIdxW-1:0];
  assign cnt_cur  = cnt_q[node_idx];
  assign sum      = {{(CalcW - COUNTER_BITS){1'b0}}, cnt_cur} + CalcW'(item_q.delta);

  // Counter update: refuse a negative result, clamp an overflow.
  always_comb begin
    if (sum[CalcW-1]) begin
      err_d   = dct_pkg::ERR_NEG;
      cnt_nxt = cnt_cur;
    end else if (|sum[CalcW-2:COUNTER_BITS]) begin
      err_d   = dct_pkg::ERR_SAT;
      cnt_nxt = CntMax;
    end else begin
      err_d   = dct_pkg::ERR_OK;
      cnt_nxt = sum[COUNTER_BITS-1:0];
    end
  end

  // Zero flags with the updated counter substituted, then the release mask.
  always_comb begin
    logic preds_done;
    for (int i = 0; i < NODE_COUNT; i++) begin
      if (node_idx == NodeIdxW'(i)) begin
        zero_v[i] = (cnt_nxt == '0);
      end else begin
        zero_v[i] = (cnt_q[i] == '0);
      end
    end
    for (int t = 0; t < NODE_COUNT; t++) begin
      preds_done = 1'b1;
      for (int s = 0; s < NODE_COUNT; s++) begin
        if (edge_q[{3'(s), 3'(t)}] && !zero_v[s]) begin
          preds_done = 1'b0;
        end
      end
      fire_d[t] = node_ok && (err_d == dct_pkg::ERR_OK) && (cnt_nxt == '0) &&
                  edge_q[{item_q.node, 3'(t)}] && !fired_q[t] && preds_done;
    end
  end

  // Lowest pending release goes out first.
  always_comb begin
    pick      = '0;
    pick_idx  = '0;
    pick_prio = '0;
    found     = 1'b0;
    for (int t = 0; t < NODE_COUNT; t++) begin
      if (fire_q[t] && !found) begin
        found     = 1'b1;
        pick[t]   = 1'b1;
        pick_idx  = 3'(t);
        pick_prio = prio_q[dct_pkg::PrioW*t +: dct_pkg::PrioW];
      end
    end
  end

  assign sts_o.last = ((fire_q & ~pick) == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q      <= '0;
      prio_q      <= '0;
      fired_q     <= '0;
      fire_q      <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < NODE_COUNT; i++) begin
        cnt_q[i] <= COUNTER_BITS'(1);
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == dct_pkg::CFG_EDGE_MATRIX) begin
          edge_q <= cfg_data_i;
        end else begin
          prio_q <= cfg_data_i[dct_pkg::PrioRegW-1:0];
        end
      end
      if (cmd_i.calc) begin
        if (node_ok && (err_d != dct_pkg::ERR_NEG)) begin
          cnt_q[node_idx] <= cnt_nxt;
        end
        fire_q  <= fire_d;
        fired_q <= fired_q | fire_d;
      end
      if (cmd_i.emit) begin
        fire_q <= fire_q & ~pick;
      end
      res_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.calc) begin
      err_q <= node_ok ? err_d : dct_pkg::ERR_OK;
    end
    if (cmd_i.emit) begin
      res_q.fired        <= found;
      res_q.task_index   <= pick_idx;
      res_q.priority_res <= pick_prio;
      res_q.error_code   <= found ? dct_pkg::ERR_OK : err_q;
      res_q.last         <= sts_o.last;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  `DCT_ASSERT_IMP(a_fired_no_err, res_valid_q && res_q.fired,
                  res_q.error_code == dct_pkg::ERR_OK, "released task carries an error")
  `DCT_ASSERT_IMP(a_fired_flag_set, res_valid_q && res_q.fired,
                  fired_q[res_q.task_index[NodeIdxW-1:0]], "released task not marked fired")
  `DCT_ASSERT_IMP(a_idle_is_last, res_valid_q && !res_q.fired,
                  res_q.last, "empty result is not the last one")
  `DCT_ASSERT_NXT(a_calc_no_strobe, cmd_i.calc,
                  !res_valid_q, "result strobe right after counter update")

endmodule

// ===== rtl/dependency_counter_task_trigger.sv =====
// Dependency counter task trigger: one item = node plus signed delta.
// The start edge loads the item register, the update state registers the release mask, and the emit
// state registers one result at a time; with n results (n = 1..8) busy_o stays high until the last.
// Results strobe once per cycle in ascending task order; the receiver cannot stall.
// Reset (async, active low) sets every counter to one, clears fired flags and config.
module dependency_counter_task_trigger #(
  parameter int NODE_COUNT   = dct_pkg::NodeCountDef,
  parameter int COUNTER_BITS = dct_pkg::CounterBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Item channel: accepted when start_i is high and busy_o is low.
  input  logic                         start_i,
  output logic                         busy_o,
  input  dct_pkg::in_item_t            item_i,
  // Result channel: each result is marked by res_valid_o.
  output dct_pkg::res_item_t           res_o,
  output logic                         res_valid_o,
  // Config write channel; always ready; the user must write only while idle, the block does not enforce it.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dct_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dct_pkg::CfgDataW-1:0] cfg_data_i
);

  // Command and status between sequencer and datapath.
  dct_pkg::dct_cmd_t cmd;
  dct_pkg::dct_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequencer: idle -> update counter and build release mask -> emit results.
  dct_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Datapath: counters, fired flags, edge and priority registers, result register.
  dct_dpath #(
    .NODE_COUNT   (NODE_COUNT),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (item_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule
